[hw/rtl/pcphm_pkg.sv]
// shared types and constants of the per-channel pedestal histogram block
`timescale 1ns / 1ps
`default_nettype none

package pcphm_pkg;

    // configuration register indexes
    localparam logic CFG_PADDLES = 1'b0;
    localparam logic CFG_PLANES  = 1'b1;

    // request kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // trigger type of pedestal events
    localparam logic [3:0] PED_TRIGGER = 4'd2;

    // counter and peak widths
    localparam int COUNT_W = 32;
    localparam int PB_W    = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register reset values
    localparam logic [5:0] PADDLES_RST = 6'd8;
    localparam logic [5:0] PLANES_RST  = 6'd4;

    // peak record of one channel
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [PB_W-1:0]    bin;
    } t_peak;

endpackage

`default_nettype wire

[hw/rtl/per_channel_pedestal_histogram_mode.sv]
// per-channel qdc histogram with running mode tracking and pedestal query
// a query reads its peak record at accept; S_CALC registers the result
// requests: a new one is stalled until the previous one has left S_CALC,
//   after the read and write-back of the bin counter and peak memories
// reset: a clearing pass zeroes the counter memory, one entry a cycle, all
//   2**(clog2(MAX_CHANNELS)+clog2(NUM_BINS)) entries (131072 at defaults)
// peak records reset through per-channel valid bits at once
`timescale 1ns / 1ps
`default_nettype none

module per_channel_pedestal_histogram_mode
    import pcphm_pkg::*;
#(
    parameter int MAX_CHANNELS = 64,
    parameter int NUM_BINS     = 2001
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [5:0]  i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [3:0]  i_trigger,
    input  wire logic [11:0] i_event_hits,
    input  wire logic [5:0]  i_plane,
    input  wire logic [5:0]  i_paddle,
    input  wire logic [1:0]  i_side,
    input  wire logic [11:0] i_qdc,
    input  wire logic [5:0]  i_query_channel,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_channel,
    output logic [10:0]      o_pedestal_bin
);

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int ADDR_W = CH_W + BIN_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } t_state;

    t_state r_state;

    // configuration registers
    logic [5:0] r_ppp;
    logic [5:0] r_pln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppp <= PADDLES_RST;
            r_pln <= PLANES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PADDLES: r_ppp <= i_cfg_data;
                CFG_PLANES:  r_pln <= i_cfg_data;
                default:     r_ppp <= r_ppp;
            endcase
        end
    end

    // request accept
    logic in_acc;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // hit decode: event cut, address checks and channel number
    logic [11:0] need_half;
    logic [12:0] need;
    logic [5:0]  pl_m1;
    logic [5:0]  pad_m1;
    logic [11:0] lin;
    logic [12:0] ch_full;
    logic        hit_ok;
    logic        q_inrng;

    always_comb begin
        need_half = 12'(r_pln) * 12'(r_ppp);
        need      = {need_half, 1'b0};
        pl_m1     = i_plane - 6'd1;
        pad_m1    = i_paddle - 6'd1;
        lin       = 12'(pl_m1) * 12'(r_ppp) + 12'(pad_m1);
        ch_full   = {lin, (i_side == 2'd2)};
        hit_ok    = (i_trigger == PED_TRIGGER)
                 && (13'(i_event_hits) >= need)
                 && (i_plane != 6'd0) && (i_plane <= r_pln)
                 && (i_paddle != 6'd0) && (i_paddle <= r_ppp)
                 && ((i_side == 2'd1) || (i_side == 2'd2))
                 && (ch_full < 13'(MAX_CHANNELS))
                 && (13'(i_qdc) < 13'(NUM_BINS));
        q_inrng   = 7'(i_query_channel) < 7'(MAX_CHANNELS);
    end

    // read addresses issued at accept
    logic [CH_W-1:0]   rd_ch;
    logic [ADDR_W-1:0] rd_addr;
    assign rd_ch   = (i_kind == KIND_QUERY) ? i_query_channel[CH_W-1:0]
                                            : ch_full[CH_W-1:0];
    assign rd_addr = {ch_full[CH_W-1:0], i_qdc[BIN_W-1:0]};

    // request registers and read data
    logic              r_kind;
    logic              r_hit_ok;
    logic              r_q_inrng;
    logic [CH_W-1:0]   r_ch;
    logic [BIN_W-1:0]  r_bin;
    logic [5:0]        r_qch;
    logic [ADDR_W-1:0] r_clr;
    logic [COUNT_W-1:0] r_cnt_rd;
    t_peak             r_pk_rd;
    logic              r_pk_rd_vld;
    logic              r_out_valid;
    logic [5:0]        r_out_ch;
    logic [10:0]       r_out_bin;

    // modify step
    logic [COUNT_W-1:0] cur_cnt;
    logic [PB_W-1:0]    cur_bin;
    logic [COUNT_W-1:0] new_cnt;
    logic [PB_W-1:0]    num;
    t_peak              pk_wdata;
    logic               cnt_we;
    logic [ADDR_W-1:0]  cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               q_load;

    always_comb begin
        cur_cnt  = r_pk_rd_vld ? r_pk_rd.cnt : '0;
        cur_bin  = r_pk_rd_vld ? r_pk_rd.bin : PB_W'(1);
        new_cnt  = r_cnt_rd + COUNT_W'(1);
        num      = PB_W'(r_bin) + PB_W'(1);
        pk_wdata.cnt = cur_cnt;
        pk_wdata.bin = cur_bin;
        if (new_cnt > cur_cnt) begin
            pk_wdata.cnt = new_cnt;
            pk_wdata.bin = num;
        end else if ((new_cnt == cur_cnt) && (num < cur_bin)) begin
            pk_wdata.bin = num;
        end
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr;
            cnt_wdata = '0;
        end else begin
            cnt_we    = (r_state == S_CALC) && (r_kind == KIND_HIT) && r_hit_ok
                     && (r_cnt_rd != COUNT_MAX);
            cnt_waddr = {r_ch, r_bin};
            cnt_wdata = new_cnt;
        end
        q_load = (r_state == S_CALC) && (r_kind == KIND_QUERY)
              && (!r_out_valid || !i_out_stall);
    end

    // bin counter memory
    logic [COUNT_W-1:0] cnt_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (in_acc) begin
            r_cnt_rd <= cnt_mem[rd_addr];
        end
    end

    // peak memory and its valid bits
    t_peak pk_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_pk_vld;
    logic pk_we;
    assign pk_we = (r_state == S_CALC) && (r_kind == KIND_HIT) && r_hit_ok
                && (r_cnt_rd != COUNT_MAX);

    always_ff @(posedge i_clk) begin
        if (pk_we) begin
            pk_mem[r_ch] <= pk_wdata;
        end
        if (in_acc) begin
            r_pk_rd     <= pk_mem[rd_ch];
            r_pk_rd_vld <= r_pk_vld[rd_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_vld <= '0;
        end else if (pk_we) begin
            r_pk_vld[r_ch] <= 1'b1;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (q_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == {ADDR_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind    <= i_kind;
                        r_hit_ok  <= hit_ok;
                        r_q_inrng <= q_inrng;
                        r_ch      <= ch_full[CH_W-1:0];
                        r_bin     <= i_qdc[BIN_W-1:0];
                        r_qch     <= i_query_channel;
                        r_state   <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (r_kind == KIND_HIT) begin
                        r_state <= S_IDLE;
                    end else if (q_load) begin
                        r_out_ch    <= r_qch;
                        r_out_bin   <= r_q_inrng ? cur_bin[10:0] : 11'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_out_ch;
    assign o_pedestal_bin = r_out_bin;

endmodule

`default_nettype wire
